// ----- hdl/rcps_pkg.sv -----
package rcps_pkg;

   localparam int CHANNELS_DEFAULT = 3;

   localparam int PIN_W      = 3;
   localparam int TS_W       = 16;
   localparam int VAL_W      = 8;
   localparam int CHAN_OUT_W = 2;
   localparam int PERIOD_W   = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 17;
   localparam int NUM_W      = TS_W + 1;
   localparam int DIV_W      = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SAVED_MIN0 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVED_MAX0 = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 8'd6;
   localparam int                   CSR_SLOTS      = 3;

   localparam logic [TS_W-1:0]     SAVED_MIN_RESET = 16'd1000;
   localparam logic [TS_W-1:0]     SAVED_MAX_RESET = 16'd2000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 17'd50000;
   localparam logic [PERIOD_W-1:0] COUNTER_SPAN    = 17'h10000;

   localparam logic [NUM_W-1:0]   STEP_ROUND  = 17'd15;
   localparam logic [NUM_W-1:0]   STEP_MASK   = ~17'd15;
   localparam logic [NUM_W-1:0]   SCALE_BIAS  = 17'd16;
   localparam logic [NUM_W:0]     RANGE_GUARD = 18'd32;
   localparam logic [NUM_W-1:0]   SCALED_MAX  = 17'd255;
   localparam logic [DIV_W-1:0]   DIV_ONE     = 8'd1;

endpackage

// ----- hdl/rc_pulse_calibrate_scale_top.sv -----
// RC pulse width measurement with range calibration and 0..255 scaling.
// req channel: one transaction per pin-change event (pin levels, timestamp,
// calibrate button). Rising edges latch the start time, falling edges each
// give one rsp transaction, in ascending channel order; last marks the final
// one of an event. Events without a falling edge give no rsp transaction.
// csr channel: always ready; index 0..2 saved min, 3..5 saved max,
// 6 counter period, other indexes ignored. Write only while idle.
// Each event is taken while idle; each falling edge then passes through
// select, measure, prepare and a 17-step restoring divide, a calibrate step
// while calibrate is held, and an emit step, with the divide done by the
// shared one-bit-per-cycle divider.
// req_ready is high only while the sequencer is idle, so a new event is
// taken only after the sequencer has left emit for the final falling edge
// of the previous one.
// The result sits in an output register; when the receiver stalls, the
// sequencer waits at emit, and after the final result it returns to idle
// and takes the next event while that result still waits.
// Reset (synchronous): levels, start times and calibration flags clear,
// saved ranges go to 1000/2000 and the counter period to 50000.
module rc_pulse_calibrate_scale_top #(
   parameter int CHANNELS = rcps_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rcps_pkg::PIN_W-1:0]       req_pin_levels,
   input  logic [rcps_pkg::TS_W-1:0]        req_timestamp,
   input  logic                             req_calibrate,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rcps_pkg::CHAN_OUT_W-1:0]  rsp_channel,
   output logic [rcps_pkg::TS_W-1:0]        rsp_pulse_width,
   output logic [rcps_pkg::VAL_W-1:0]       rsp_scaled_value,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rcps_pkg::*;

   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LANES_W = (CHANNELS > PIN_W) ? CHANNELS : PIN_W;
   localparam int CNT_W   = $clog2(NUM_W);

   typedef enum logic [2:0] {
      IDLE, PICK, MEAS, CALIB, PREP, DIV, EMIT
   } state_type;

   state_type                  state_ff;
   logic [PIN_W-1:0]           prev_ff;
   logic [CHANNELS-1:0]        pending_ff;
   logic [TS_W-1:0]            pulse_start_ff [CHANNELS];
   logic [CHANNELS-1:0]        is_cal_ff;
   logic [TS_W-1:0]            learned_min_ff [CHANNELS];
   logic [TS_W-1:0]            learned_max_ff [CHANNELS];
   logic [TS_W-1:0]            saved_min_ff   [CHANNELS];
   logic [TS_W-1:0]            saved_max_ff   [CHANNELS];
   logic [PERIOD_W-1:0]        period_ff;
   logic [CH_W-1:0]            ch_ff;
   logic [TS_W-1:0]            t_ff;
   logic                       cal_ff;
   logic                       last_ff;
   logic [TS_W-1:0]            w_ff;
   logic [NUM_W-1:0]           num_ff;
   logic [NUM_W-1:0]           quo_ff;
   logic [DIV_W-1:0]           rem_ff;
   logic [DIV_W-1:0]           div_ff;
   logic                       zero_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       rsp_valid_ff;
   logic [CHAN_OUT_W-1:0]      rsp_channel_ff;
   logic [TS_W-1:0]            rsp_width_ff;
   logic [VAL_W-1:0]           rsp_value_ff;
   logic                       rsp_last_ff;

   logic [PIN_W-1:0]           mask;
   logic [PIN_W-1:0]           curr;
   logic [LANES_W-1:0]         fall_wide;
   logic [LANES_W-1:0]         rise_wide;
   logic [CHANNELS-1:0]        falls;
   logic [CH_W-1:0]            pick_idx;
   logic [CHANNELS-1:0]        pending_rest;
   logic [TS_W-1:0]            start_sel;
   logic [TS_W-1:0]            corr;
   logic [TS_W-1:0]            w_in;
   logic [TS_W-1:0]            base_min;
   logic [TS_W-1:0]            base_max;
   logic [NUM_W-1:0]           dmin_r;
   logic [NUM_W-1:0]           dmax_r;
   logic [NUM_W:0]             nmax;
   logic [TS_W-1:0]            new_min_in;
   logic [TS_W-1:0]            new_max_in;
   logic [TS_W-1:0]            act_min;
   logic [TS_W-1:0]            act_max;
   logic [NUM_W:0]             span;
   logic [DIV_W-1:0]           div_in;
   logic [DIV_W:0]             rem_sh;
   logic [DIV_W:0]             rem_sub;
   logic                       rem_ge;
   logic [VAL_W-1:0]           value_in;

   assign req_ready = (state_ff == IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_pulse_width  = rsp_width_ff;
   assign rsp_scaled_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   always_comb begin
      for (int i = 0; i < PIN_W; i++) begin
         mask[i] = (i < CHANNELS);
      end
      curr      = req_pin_levels & mask;
      fall_wide = LANES_W'((curr ^ prev_ff) & ~curr);
      rise_wide = LANES_W'((curr ^ prev_ff) & curr);
      falls     = fall_wide[CHANNELS-1:0];
   end

   always_comb begin
      pick_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick_idx = CH_W'(i);
         end
      end
      pending_rest = pending_ff & (pending_ff - CHANNELS'(1));
   end

   always_comb begin
      start_sel = pulse_start_ff[ch_ff];
      corr      = TS_W'(COUNTER_SPAN - period_ff);
      w_in      = t_ff - start_sel;
      if (t_ff < start_sel) begin
         w_in = w_in - corr;
      end
   end

   always_comb begin
      base_min = is_cal_ff[ch_ff] ? learned_min_ff[ch_ff] : w_ff;
      base_max = is_cal_ff[ch_ff] ? learned_max_ff[ch_ff] : w_ff;
      dmin_r   = (({1'b0, base_min} - {1'b0, w_ff}) + STEP_ROUND) & STEP_MASK;
      dmax_r   = (({1'b0, w_ff} - {1'b0, base_max}) + STEP_ROUND) & STEP_MASK;
      nmax     = {2'b00, base_max} + {1'b0, dmax_r};
      new_min_in = base_min;
      if (w_ff < base_min) begin
         if (dmin_r > {1'b0, base_min}) begin
            new_min_in = '0;
         end else begin
            new_min_in = base_min - dmin_r[TS_W-1:0];
         end
      end
      new_max_in = base_max;
      if (w_ff > base_max) begin
         new_max_in = nmax[NUM_W:TS_W] != '0 ? '1 : nmax[TS_W-1:0];
      end
   end

   always_comb begin
      act_min = is_cal_ff[ch_ff] ? learned_min_ff[ch_ff] : saved_min_ff[ch_ff];
      act_max = is_cal_ff[ch_ff] ? learned_max_ff[ch_ff] : saved_max_ff[ch_ff];
      span    = {2'b00, act_max} - {2'b00, act_min} - RANGE_GUARD;
      if (span[NUM_W] || span[TS_W-1:DIV_W] == '0) begin
         div_in = DIV_ONE;
      end else begin
         div_in = span[TS_W-1:DIV_W];
      end
   end

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      rem_ge  = rem_sh >= {1'b0, div_ff};
      rem_sub = rem_sh - {1'b0, div_ff};
      if (zero_ff) begin
         value_in = '0;
      end else if (quo_ff > SCALED_MAX) begin
         value_in = VAL_W'(SCALED_MAX);
      end else begin
         value_in = quo_ff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         prev_ff      <= '0;
         pending_ff   <= '0;
         is_cal_ff    <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            pulse_start_ff[c] <= '0;
            saved_min_ff[c]   <= SAVED_MIN_RESET;
            saved_max_ff[c]   <= SAVED_MAX_RESET;
         end
      end else begin
         if (csr_valid) begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (c < CSR_SLOTS && csr_index == CSR_SAVED_MIN0 + CSR_IDX_W'(c)) begin
                  saved_min_ff[c] <= csr_data[TS_W-1:0];
               end
               if (c < CSR_SLOTS && csr_index == CSR_SAVED_MAX0 + CSR_IDX_W'(c)) begin
                  saved_max_ff[c] <= csr_data[TS_W-1:0];
               end
            end
            if (csr_index == CSR_PERIOD) begin
               period_ff <= csr_data;
            end
         end

         if (rsp_valid_ff && rsp_ready && state_ff != EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  prev_ff    <= curr;
                  pending_ff <= falls;
                  t_ff       <= req_timestamp;
                  cal_ff     <= req_calibrate;
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (rise_wide[c]) begin
                        pulse_start_ff[c] <= req_timestamp;
                     end
                  end
                  state_ff <= (falls != '0) ? PICK : IDLE;
               end
            end
            PICK: begin
               ch_ff      <= pick_idx;
               pending_ff <= pending_rest;
               last_ff    <= (pending_rest == '0);
               state_ff   <= MEAS;
            end
            MEAS: begin
               w_ff     <= w_in;
               state_ff <= cal_ff ? CALIB : PREP;
            end
            CALIB: begin
               learned_min_ff[ch_ff] <= new_min_in;
               learned_max_ff[ch_ff] <= new_max_in;
               is_cal_ff[ch_ff]      <= 1'b1;
               state_ff              <= PREP;
            end
            PREP: begin
               div_ff   <= div_in;
               zero_ff  <= (w_ff < act_min);
               num_ff   <= {1'b0, w_ff} - {1'b0, act_min} + SCALE_BIAS;
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               rem_ff <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
               quo_ff <= {quo_ff[NUM_W-2:0], rem_ge};
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(NUM_W - 1)) begin
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_channel_ff <= CHAN_OUT_W'(ch_ff);
                  rsp_width_ff   <= w_ff;
                  rsp_value_ff   <= value_in;
                  rsp_last_ff    <= last_ff;
                  state_ff       <= (pending_ff == '0) ? IDLE : PICK;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_no_fall_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && falls == '0) |=> req_ready)
      else $error("event without falling edge left the sequencer busy");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV) |-> (div_ff != '0))
      else $error("zero divisor in divide loop");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == EMIT))
      else $error("result dropped while output register busy");

   a_last_ends_event: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT && rsp_valid_ff == 1'b0 && last_ff) |-> (pending_ff == '0))
      else $error("last flag set with falling edges still pending");

endmodule
